// ===== rtl/mwrf_pkg.sv =====
// shared types and constants of the median-of-window range filter
package mwrf_pkg;

  localparam int unsigned WINDOW_DEF = 10;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned DIST_W   = 25;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'h0100;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 24'h000000;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_SCAN = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } mwrf_state_e;

  // rank counter control from the sequencer
  typedef struct packed {
    logic clear;
    logic step;
  } mwrf_rank_ctrl_t;

endpackage

// ===== rtl/mwrf_store.sv =====
// generic ram: one write port, one registered read port
module mwrf_store #(
  parameter int unsigned WIDTH  = mwrf_pkg::SAMPLE_W,
  parameter int unsigned DEPTH  = mwrf_pkg::WINDOW_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // a read of the address being written returns the new data
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mwrf_rank.sv =====
// shared compare unit and rank counter for the median selection
module mwrf_rank #(
  parameter int unsigned WINDOW = mwrf_pkg::WINDOW_DEF,
  parameter int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mwrf_pkg::mwrf_rank_ctrl_t     ctrl_i,
  input  logic [mwrf_pkg::SAMPLE_W-1:0] cand_i,
  input  logic [mwrf_pkg::SAMPLE_W-1:0] scan_i,
  input  logic                          tie_wins_i,
  output logic [IDX_W-1:0]              rank_next_o
);

  logic [IDX_W-1:0] rank_q, rank_d;
  logic             below;

  // scan element sorts before the candidate: smaller, or equal and earlier
  assign below       = (scan_i < cand_i) || ((scan_i == cand_i) && tie_wins_i);
  assign rank_next_o = IDX_W'(rank_q + IDX_W'(below));

  always_comb begin
    rank_d = rank_q;
    if (ctrl_i.clear) begin
      rank_d = '0;
    end else if (ctrl_i.step) begin
      rank_d = rank_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

endmodule

// ===== rtl/mwrf_dist.sv =====
// distance datapath: registered gain product, then offset add
module mwrf_dist (
  input  logic                                 clk_i,
  input  logic                                 mul_en_i,
  input  logic signed [mwrf_pkg::GAIN_W-1:0]   gain_i,
  input  logic        [mwrf_pkg::SAMPLE_W-1:0] median_i,
  input  logic signed [mwrf_pkg::OFFSET_W-1:0] offset_i,
  output logic signed [mwrf_pkg::DIST_W-1:0]   distance_o
);

  localparam int unsigned DW = mwrf_pkg::DIST_W;
  localparam int unsigned GW = mwrf_pkg::GAIN_W;
  localparam int unsigned SW = mwrf_pkg::SAMPLE_W;
  localparam int unsigned OW = mwrf_pkg::OFFSET_W;

  logic signed [DW-1:0] gain_ext, med_ext, off_ext, prod_d, prod_q;

  assign gain_ext = {{(DW-GW){gain_i[GW-1]}}, gain_i};
  assign med_ext  = {{(DW-SW){1'b0}}, median_i};
  assign off_ext  = {{(DW-OW){offset_i[OW-1]}}, offset_i};

  // true product fits in 25 bits, truncation is exact
  assign prod_d = gain_ext * med_ext;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  assign distance_o = prod_q + off_ext;

endmodule

// ===== rtl/median_of_window_range_filter_core.sv =====
// top level of the median-of-window range filter: sequencer, registers, output stage
// a clean sample that does not complete the window is stored and counted at acceptance;
//   the error result is visible the cycle after acceptance
// a completing sample starts the rank search: one compare per cycle, each candidate scanned
//   over the whole window; then busy until the median is out
// throughput: one sample per cycle while the window fills and no result waits
// reset: async active low, clears fill count, sequencer, output valid; gain=1.0, offset=0
module median_of_window_range_filter_core #(
  parameter int unsigned WINDOW = mwrf_pkg::WINDOW_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic        [mwrf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [mwrf_pkg::CFG_W-1:0]    cfg_wdata_i,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [mwrf_pkg::SAMPLE_W-1:0] range_sample_i,
  input  logic                                 sample_error_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 failed_o,
  output logic        [mwrf_pkg::SAMPLE_W-1:0] median_range_o,
  output logic signed [mwrf_pkg::DIST_W-1:0]   distance_o
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0] MED_IDX = IDX_W'((WINDOW - 1) / 2);

  // configuration registers
  logic signed [mwrf_pkg::GAIN_W-1:0]   gain_q;
  logic signed [mwrf_pkg::OFFSET_W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= mwrf_pkg::GAIN_RST;
      offset_q <= mwrf_pkg::OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mwrf_pkg::CFG_GAIN:   gain_q   <= cfg_wdata_i[mwrf_pkg::GAIN_W-1:0];
        mwrf_pkg::CFG_OFFSET: offset_q <= cfg_wdata_i[mwrf_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  mwrf_pkg::mwrf_state_e state_q, state_d;
  logic [IDX_W-1:0] fill_q, fill_d;   // samples held in the current window
  logic [IDX_W-1:0] cand_idx_q, cand_idx_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;

  // datapath registers
  logic [mwrf_pkg::SAMPLE_W-1:0] cand_q, cand_d;
  logic [mwrf_pkg::SAMPLE_W-1:0] med_q, med_d;

  // output stage
  logic                                 out_valid_q, out_valid_d;
  logic                                 failed_q, failed_d;
  logic        [mwrf_pkg::SAMPLE_W-1:0] median_q, median_d;
  logic signed [mwrf_pkg::DIST_W-1:0]   dist_q, dist_d;

  logic                                 in_fire;
  logic                                 out_free;
  logic                                 store_we;
  logic        [IDX_W-1:0]              rd_addr;
  logic        [mwrf_pkg::SAMPLE_W-1:0] rd_data;
  logic        [IDX_W-1:0]              rank_next;
  mwrf_pkg::mwrf_rank_ctrl_t            rank_ctrl;
  logic                                 mul_en;
  logic signed [mwrf_pkg::DIST_W-1:0]   dist_sum;

  // output slot is free now or frees at this edge
  assign out_free = !out_valid_q || out_ready_i;

  // a sample that yields no result can go in even while a result waits
  assign in_ready_o = (state_q == mwrf_pkg::S_IDLE) &&
                      (out_free || (!sample_error_i && (fill_q != LAST)));
  assign in_fire    = in_valid_i && in_ready_o;

  assign store_we = in_fire && !sample_error_i;
  // store read is registered, so the address is taken from the next values of the index registers
  assign rd_addr  = (state_d == mwrf_pkg::S_LOAD) ? cand_idx_d : scan_idx_d;

  mwrf_store #(
    .WIDTH  (mwrf_pkg::SAMPLE_W),
    .DEPTH  (WINDOW),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (fill_q),
    .wdata_i (range_sample_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // rank of the candidate: count of entries that sort before it
  assign rank_ctrl.clear = (state_q == mwrf_pkg::S_LOAD);
  assign rank_ctrl.step  = (state_q == mwrf_pkg::S_SCAN);

  mwrf_rank #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rank_ctrl),
    .cand_i      (cand_q),
    .scan_i      (rd_data),
    .tie_wins_i  (scan_idx_q < cand_idx_q),
    .rank_next_o (rank_next)
  );

  assign mul_en = (state_q == mwrf_pkg::S_MUL);

  mwrf_dist u_dist (
    .clk_i      (clk_i),
    .mul_en_i   (mul_en),
    .gain_i     (gain_q),
    .median_i   (med_q),
    .offset_i   (offset_q),
    .distance_o (dist_sum)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cand_idx_d  = cand_idx_q;
    scan_idx_d  = scan_idx_q;
    cand_d      = cand_q;
    med_d       = med_q;
    out_valid_d = out_valid_q && !out_ready_i;
    failed_d    = failed_q;
    median_d    = median_q;
    dist_d      = dist_q;

    unique case (state_q)
      mwrf_pkg::S_IDLE: begin
        if (in_fire) begin
          if (sample_error_i) begin
            // aborted window: failure transaction, count cleared
            fill_d      = '0;
            out_valid_d = 1'b1;
            failed_d    = 1'b1;
            median_d    = '0;
            dist_d      = '0;
          end else if (fill_q == LAST) begin
            fill_d     = '0;
            cand_idx_d = '0;
            state_d    = mwrf_pkg::S_LOAD;
          end else begin
            fill_d = IDX_W'(fill_q + 1'b1);
          end
        end
      end
      mwrf_pkg::S_LOAD: begin
        cand_d     = rd_data;
        scan_idx_d = '0;
        state_d    = mwrf_pkg::S_SCAN;
      end
      mwrf_pkg::S_SCAN: begin
        if (scan_idx_q == LAST) begin
          if (rank_next == MED_IDX) begin
            med_d   = cand_q;
            state_d = mwrf_pkg::S_MUL;
          end else begin
            cand_idx_d = IDX_W'(cand_idx_q + 1'b1);
            state_d    = mwrf_pkg::S_LOAD;
          end
        end else begin
          scan_idx_d = IDX_W'(scan_idx_q + 1'b1);
        end
      end
      mwrf_pkg::S_MUL: begin
        state_d = mwrf_pkg::S_EMIT;
      end
      mwrf_pkg::S_EMIT: begin
        // hold until the output slot is free
        if (out_free) begin
          out_valid_d = 1'b1;
          failed_d    = 1'b0;
          median_d    = med_q;
          dist_d      = dist_sum;
          state_d     = mwrf_pkg::S_IDLE;
        end
      end
      default: state_d = mwrf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwrf_pkg::S_IDLE;
      fill_q      <= '0;
      cand_idx_q  <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cand_idx_q  <= cand_idx_d;
      scan_idx_q  <= scan_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    med_q    <= med_d;
    failed_q <= failed_d;
    median_q <= median_d;
    dist_q   <= dist_d;
  end

  assign out_valid_o    = out_valid_q;
  assign failed_o       = failed_q;
  assign median_range_o = median_q;
  assign distance_o     = dist_q;

  // a failure transaction carries zero payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && failed_o) |-> (median_range_o == '0 && distance_o == '0))
    else $error("failure transaction with nonzero payload");

  // a completing sample starts the rank search
  a_full_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !sample_error_i && fill_q == LAST) |=>
      (state_q == mwrf_pkg::S_LOAD && fill_q == '0 && cand_idx_q == '0))
    else $error("full window did not start the rank search");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q && $stable(failed_q) && $stable(median_q) && $stable(dist_q)))
    else $error("pending result overwritten");

  // window indices stay inside the store
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= LAST) && (scan_idx_q <= LAST) && (cand_idx_q <= LAST))
    else $error("window index out of range");

  // the median candidate is always found before the candidates run out
  a_cand_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwrf_pkg::S_SCAN && scan_idx_q == LAST && cand_idx_q == LAST) |->
      (rank_next == MED_IDX))
    else $error("no candidate had the median rank");

endmodule

// ===== test/median_of_window_range_filter_core_test.sv =====
// self-checking testbench of the median-of-window range filter core
module median_of_window_range_filter_core_test;

  localparam int unsigned WIN = mwrf_pkg::WINDOW_DEF;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 12;
  // sized from the worst case of the rank search, kept with margin
  localparam int unsigned SETTLE_CYCLES = WIN * (WIN + 1) + 20;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned GAP_MAX = 4;

  typedef struct packed {
    logic                                failed;
    logic [mwrf_pkg::SAMPLE_W-1:0]       median;
    logic signed [mwrf_pkg::DIST_W-1:0]  distance;
  } range_result_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [mwrf_pkg::CFG_IDX_W-1:0]       cfg_idx_i;
  logic [mwrf_pkg::CFG_W-1:0]           cfg_wdata_i;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic [mwrf_pkg::SAMPLE_W-1:0]        range_sample_i;
  logic                                 sample_error_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic                                 failed_o;
  logic [mwrf_pkg::SAMPLE_W-1:0]        median_range_o;
  logic signed [mwrf_pkg::DIST_W-1:0]   distance_o;

  // predictor state: a copy of the window, its fill level and both registers
  logic [mwrf_pkg::SAMPLE_W-1:0]        window_samples [WIN];
  int unsigned                          fill_cnt = 0;
  logic [mwrf_pkg::GAIN_W-1:0]          gain_reg = mwrf_pkg::GAIN_RST;
  logic [mwrf_pkg::OFFSET_W-1:0]        offset_reg = mwrf_pkg::OFFSET_RST;
  range_result_t                        expected_results [$];

  int unsigned                          mismatches = 0;
  int unsigned                          idle_cycles = 0;
  int unsigned                          stall_left = 0;
  // set on the falling edge ahead of the rising edge that completes a transaction
  bit                                   in_take = 1'b0;
  bit                                   out_take = 1'b0;
  // when set, the sender or the receiver runs without idle cycles
  bit                                   no_gaps = 1'b0;
  bit                                   no_stalls = 1'b0;

  median_of_window_range_filter_core #(
    .WINDOW(WIN)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_sample_i (range_sample_i),
    .sample_error_i (sample_error_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .failed_o       (failed_o),
    .median_range_o (median_range_o),
    .distance_o     (distance_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // insertion sort of a copy of the window, lower median picked out
  function automatic logic [mwrf_pkg::SAMPLE_W-1:0] lower_median();
    logic [mwrf_pkg::SAMPLE_W-1:0] sorted [WIN];
    logic [mwrf_pkg::SAMPLE_W-1:0] v;
    int j;
    for (int i = 0; i < WIN; i++) sorted[i] = window_samples[i];
    for (int i = 1; i < WIN; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[(WIN-1)/2];
  endfunction

  // update the window copy with one accepted sample and queue what it yields
  task automatic predict_sample(input logic [mwrf_pkg::SAMPLE_W-1:0] sample,
                                input logic err);
    range_result_t res;
    longint d;
    if (err) begin
      // sensor error: window thrown away, failure result with zero fields
      fill_cnt = 0;
      res.failed = 1'b1;
      res.median = '0;
      res.distance = '0;
      expected_results.push_back(res);
    end else begin
      window_samples[fill_cnt] = sample;
      fill_cnt++;
      if (fill_cnt == WIN) begin
        fill_cnt = 0;
        res.failed = 1'b0;
        res.median = lower_median();
        // exact signed product plus offset, fits in the distance width
        d = longint'($signed(gain_reg)) * longint'(res.median) +
            longint'($signed(offset_reg));
        res.distance = d[mwrf_pkg::DIST_W-1:0];
        expected_results.push_back(res);
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) $display("mismatch: %s", msg);
  endtask

  task automatic check_result();
    range_result_t exp_res;
    if (expected_results.size() == 0) begin
      note_mismatch($sformatf("unexpected result failed=%0b median=%0d distance=%0d",
                              failed_o, median_range_o, distance_o));
    end else begin
      exp_res = expected_results.pop_front();
      if (failed_o !== exp_res.failed)
        note_mismatch($sformatf("failed expected %0b, got %0b", exp_res.failed, failed_o));
      if (median_range_o !== exp_res.median)
        note_mismatch($sformatf("median_range expected %0d, got %0d",
                                exp_res.median, median_range_o));
      if (distance_o !== exp_res.distance)
        note_mismatch($sformatf("distance expected %0d, got %0d",
                                exp_res.distance, distance_o));
    end
  endtask

  // everything is looked at on the falling edge, where inputs and outputs are stable;
  // a valid/ready pair seen high here completes a transaction at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_sample(range_sample_i, sample_error_i);
        in_take = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        check_result();
        out_take = 1'b1;
      end
      // watchdog on cycles without any transaction
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("median_of_window_range_filter_core_test: errors");
          $finish;
        end
      end
    end
  end

  // result side: after each result a fresh random stall is drawn, none when no_stalls is set
  always @(posedge clk_i) begin
    if (out_take) begin
      out_take = 1'b0;
      stall_left = no_stalls ? 0 : $urandom_range(0, GAP_MAX);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_ready_i <= (stall_left == 0);
  end

  // one sample transaction; entered and left at a rising edge
  task automatic send_sample(input logic [mwrf_pkg::SAMPLE_W-1:0] sample, input logic err);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    range_sample_i <= sample;
    sample_error_i <= err;
    do @(posedge clk_i); while (!in_take);
    in_take = 1'b0;
  endtask

  // stop sending, wait for every queued result and let the sequencer settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called while the core is idle
  task automatic write_reg(input logic [mwrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mwrf_pkg::CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mwrf_pkg::CFG_GAIN:   gain_reg = data[mwrf_pkg::GAIN_W-1:0];
      mwrf_pkg::CFG_OFFSET: offset_reg = data[mwrf_pkg::OFFSET_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // sample values mixing full range, tight clusters with duplicates and the extremes
  function automatic logic [mwrf_pkg::SAMPLE_W-1:0] draw_range();
    case ($urandom_range(0, 3))
      0: return mwrf_pkg::SAMPLE_W'($urandom_range(0, 255));
      1: return mwrf_pkg::SAMPLE_W'($urandom_range(120, 123));
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return mwrf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic run_random_items(input int unsigned n_items);
    int unsigned sent;
    int unsigned k;
    int unsigned r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        // complete clean window
        repeat (WIN) send_sample(draw_range(), 1'b0);
        sent += WIN;
      end else if (r < 18) begin
        // window broken by an error at any fill level
        k = $urandom_range(0, WIN - 1);
        repeat (k) send_sample(draw_range(), 1'b0);
        send_sample(draw_range(), 1'b1);
        sent += k + 1;
      end else begin
        // loose samples with random error flags
        repeat (3) send_sample(draw_range(), 1'($urandom_range(0, 1)));
        sent += 3;
      end
      // now and then hold off until the core has caught up completely
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  // reset register values, errors on an empty and a partial window
  task automatic test_defaults_and_errors();
    send_sample(8'hFF, 1'b1);
    send_sample(8'h00, 1'b1);
    for (int i = 0; i < WIN; i++) send_sample((i % 2) ? 8'hFF : 8'h00, 1'b0);
    for (int i = 0; i < 4; i++) send_sample(8'hA5 ^ 8'(i), 1'b0);
    send_sample(8'h5A, 1'b1);
    for (int i = 0; i < WIN; i++) send_sample(8'(WIN - i), 1'b0);
  endtask

  // register extremes, junk in the unused upper bits of the gain write
  task automatic test_register_extremes();
    logic signed [mwrf_pkg::GAIN_W-1:0]   gains   [5] =
      '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sh0100};
    logic signed [mwrf_pkg::OFFSET_W-1:0] offsets [5] =
      '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'sh7FFFFF, 24'sh800000};
    for (int s = 0; s < 5; s++) begin
      drain();
      write_reg(mwrf_pkg::CFG_GAIN, {8'($urandom), gains[s]});
      write_reg(mwrf_pkg::CFG_OFFSET, offsets[s]);
      repeat (WIN) send_sample(8'hFF, 1'b0);
      repeat (WIN) send_sample(draw_range(), 1'b0);
    end
  endtask

  // random phases with new register values; phases 1 and 3 send back to back, phases 2 and 3 never stall results
  task automatic test_random_phases();
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(mwrf_pkg::CFG_GAIN, mwrf_pkg::CFG_W'($urandom));
      write_reg(mwrf_pkg::CFG_OFFSET, mwrf_pkg::CFG_W'($urandom));
      no_gaps   = (p == 1) || (p == 3);
      no_stalls = (p == 2) || (p == 3);
      run_random_items(200);
    end
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= mwrf_pkg::CFG_GAIN;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    range_sample_i <= '0;
    sample_error_i <= 1'b0;
    out_ready_i    <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_and_errors();
    test_register_extremes();
    test_random_phases();
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("median_of_window_range_filter_core_test: clean");
    end else begin
      $display("median_of_window_range_filter_core_test: errors");
    end
    $finish;
  end

endmodule
